/* sv/dvst_pkg.sv */
// Shared types, codes and compare functions for the value set table.
// Used by dvst_ctrl, dvst_dpath and dedup_value_set_table.
package dvst_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 64;
    localparam int OP_W          = 2;
    localparam int POS_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HOLD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [VALUE_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [VALUE_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic load_req;
        logic compare;
        logic commit;
    } dvst_cmd_t;

    function automatic logic is_nan(input logic [VALUE_W-1:0] v);
        return ((v & EXP_MASK) == EXP_MASK) && ((v & FRAC_MASK) != '0);
    endfunction

    function automatic logic ieee_equal(input logic [VALUE_W-1:0] a,
                                        input logic [VALUE_W-1:0] b);
        logic eq;
        if (is_nan(a) || is_nan(b))
            eq = 1'b0;
        else if (((a | b) & MAG_MASK) == '0)
            eq = 1'b1;
        else
            eq = (a == b);
        return eq;
    endfunction

endpackage

/* sv/dvst_ctrl.sv */
// Request sequencer for the value set table: accept, compare, resolve.
// Depends on dvst_pkg; drives dvst_dpath through dvst_cmd_t.
module dvst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output dvst_pkg::dvst_cmd_t cmd
);
    import dvst_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;
    logic       commit;

    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_RES) && out_free;
    assign in_stall = !((state_reg == S_IDLE) || commit);
    assign accept   = in_valid && !in_stall;

    assign cmd.load_req = accept;
    assign cmd.compare  = (state_reg == S_CMP);
    assign cmd.commit   = commit;
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                // take the next request in the resolve cycle
                if (commit)
                    state_next = accept ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/dvst_dpath.sv */
// Entry storage, parallel compare, first-match resolve and result register.
// Depends on dvst_pkg; commanded by dvst_ctrl.
module dvst_dpath #(
    parameter int DEPTH = dvst_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dvst_pkg::dvst_cmd_t           cmd,
    input  logic [dvst_pkg::OP_W-1:0]     op,
    input  logic [dvst_pkg::VALUE_W-1:0]  value,
    output logic                          found,
    output logic [dvst_pkg::POS_W-1:0]    position,
    output logic [dvst_pkg::STATUS_W-1:0] status,
    output logic [dvst_pkg::OCC_W-1:0]    occupancy
);
    import dvst_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0]  entry_reg [DEPTH];
    logic [VALUE_W-1:0]  entry_next [DEPTH];
    logic [VALUE_W-1:0]  shift_src [DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [OP_W-1:0]     op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [DEPTH-1:0]    match_reg;
    logic [DEPTH-1:0]    match_next;
    logic                found_reg;
    logic [POS_W-1:0]    position_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [OCC_W-1:0]    occupancy_reg;

    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [STATUS_W-1:0] status_next;
    logic                do_insert;
    logic                do_remove;

    genvar g;
    generate
        for (g = 0; g < DEPTH - 1; g++)
        begin : g_shift
            assign shift_src[g] = entry_reg[g + 1];
        end
    endgenerate
    assign shift_src[DEPTH-1] = entry_reg[DEPTH-1];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            match_next[i] = (CNT_W'(i) < count_reg) && ieee_equal(entry_reg[i], value_reg);
    end

    // pick the lowest matching slot
    always_comb
    begin
        hit     = |match_reg;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                hit_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        status_next = ST_DONE;
        if (op_reg == OP_INSERT)
        begin
            if (hit)
                status_next = ST_HOLD;
            else if (count_reg == CNT_W'(DEPTH))
                status_next = ST_FULL;
            else
                do_insert = 1'b1;
        end
        else if (op_reg == OP_REMOVE)
        begin
            if (!hit)
                status_next = ST_HOLD;
            else
                do_remove = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (do_remove)
            count_next = count_reg - CNT_W'(1);
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (do_insert && (CNT_W'(i) == count_reg))
                entry_next[i] = value_reg;
            else if (do_remove && (IDX_W'(i) >= hit_idx))
                entry_next[i] = shift_src[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < DEPTH; i++)
                entry_reg[i] <= entry_next[i];
            found_reg     <= hit;
            position_reg  <= hit ? POS_W'(hit_idx) : '0;
            status_reg    <= status_next;
            occupancy_reg <= OCC_W'(count_next);
        end
        if (cmd.load_req)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (cmd.compare)
            match_reg <= match_next;
    end

    assign found     = found_reg;
    assign position  = position_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

/* sv/dedup_value_set_table.sv */
// Top level of the insertion-ordered value set table.
// Depends on dvst_pkg, dvst_ctrl and dvst_dpath.
//
// A request (op, value) is first compared against every stored entry at once
// into a registered match vector; then the first match is resolved and the
// insert or remove applied, which loads the result register. The next
// request is taken in that resolve cycle while the result side keeps up, so
// a new request can be accepted as the last one resolves; a stalled result
// holds the block in the resolve cycle until it is taken. Entries need no
// clearing after reset; the request channel is ready at once.
module dedup_value_set_table #(
    parameter int DEPTH = dvst_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dvst_pkg::OP_W-1:0]     op,
    input  logic [dvst_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [dvst_pkg::POS_W-1:0]    position,
    output logic [dvst_pkg::STATUS_W-1:0] status,
    output logic [dvst_pkg::OCC_W-1:0]    occupancy
);
    import dvst_pkg::*;

    dvst_cmd_t cmd;

    dvst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    dvst_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (op),
        .value     (value),
        .found     (found),
        .position  (position),
        .status    (status),
        .occupancy (occupancy)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for dedup_value_set_table: directed table, then random requests.
// Depends on dvst_pkg and the dedup_value_set_table RTL; predicts each reply not typed in the table.
module tb;
    import dvst_pkg::*;

    localparam int TABLE_DEPTH      = DEPTH_DEFAULT;
    localparam int POOL_N           = 20;
    localparam int RANDOM_PER_PHASE = 625;
    localparam int LIMIT_CYCLES     = 400000;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } set_reply_t;

    typedef struct packed {
        logic [OP_W-1:0]    r_op;
        logic [VALUE_W-1:0] r_val;
        logic               typed;
        set_reply_t         want;
    } dir_row_t;

    localparam logic        TYPED     = 1'b1;
    localparam logic [12:0] PREDICTED = 13'h0;

    localparam dir_row_t DIRECTED [27] = '{
        {OP_LOOKUP, 64'h0000_0000_0000_0000, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd0},
        {OP_REMOVE, 64'h0000_0000_0000_0000, TYPED, 1'b0, 4'd0,  ST_HOLD, 5'd0},
        {OP_INSERT, 64'h0000_0000_0000_0000, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd1},
        {OP_INSERT, 64'h8000_0000_0000_0000, TYPED, 1'b1, 4'd0,  ST_HOLD, 5'd1},
        {OP_SPARE,  64'h8000_0000_0000_0000, TYPED, 1'b1, 4'd0,  ST_DONE, 5'd1},
        {OP_INSERT, 64'h7FF8_0000_0000_0001, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd2},
        {OP_INSERT, 64'h7FF8_0000_0000_0001, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd3},
        {OP_REMOVE, 64'h7FF8_0000_0000_0001, TYPED, 1'b0, 4'd0,  ST_HOLD, 5'd3},
        {OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd3},
        {OP_INSERT, 64'h7FF0_0000_0000_0000, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd4},
        {OP_INSERT, 64'hFFF0_0000_0000_0000, TYPED, 1'b0, 4'd0,  ST_DONE, 5'd5},
        {OP_REMOVE, 64'h8000_0000_0000_0000, TYPED, 1'b1, 4'd0,  ST_DONE, 5'd4},
        {OP_INSERT, 64'h0000_0000_0000_0001, PREDICTED},
        {OP_INSERT, 64'h7FEF_FFFF_FFFF_FFFF, PREDICTED},
        {OP_INSERT, 64'hFFEF_FFFF_FFFF_FFFF, PREDICTED},
        {OP_INSERT, 64'h3FF0_0000_0000_0000, PREDICTED},
        {OP_INSERT, 64'hBFF0_0000_0000_0000, PREDICTED},
        {OP_INSERT, 64'h0010_0000_0000_0000, PREDICTED},
        {OP_INSERT, 64'h8000_0000_0000_0001, PREDICTED},
        {OP_INSERT, 64'h5555_5555_5555_5555, PREDICTED},
        {OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, PREDICTED},
        {OP_INSERT, 64'h000F_FFFF_FFFF_FFFF, PREDICTED},
        {OP_INSERT, 64'h1234_5678_9ABC_DEF0, PREDICTED},
        {OP_INSERT, 64'h4000_0000_0000_0000, PREDICTED},
        {OP_INSERT, 64'h7FF0_0000_0000_0001, TYPED, 1'b0, 4'd0,  ST_FULL, 5'd16},
        {OP_LOOKUP, 64'h4000_0000_0000_0000, TYPED, 1'b1, 4'd15, ST_DONE, 5'd16},
        {OP_REMOVE, 64'h7FF0_0000_0000_0000, PREDICTED}
    };

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op        = OP_LOOKUP;
    logic [VALUE_W-1:0]  value     = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    logic [VALUE_W-1:0] held_values [TABLE_DEPTH];
    int                 held_count = 0;
    logic [VALUE_W-1:0] pool [POOL_N];
    set_reply_t         pending_replies [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int requests_sent = 0;
    int replies_seen  = 0;
    int hit_count     = 0;
    int refused_count = 0;
    int mismatches    = 0;
    int cycles        = 0;

    dedup_value_set_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .position  (position),
        .status    (status),
        .occupancy (occupancy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic nan_pattern(input logic [VALUE_W-1:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
    endfunction

    function automatic logic same_number(input logic [VALUE_W-1:0] a,
                                         input logic [VALUE_W-1:0] b);
        if (nan_pattern(a) || nan_pattern(b))
            return 1'b0;
        if (a[62:0] == '0 && b[62:0] == '0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic set_reply_t predict_reply(input logic [OP_W-1:0]    req_op,
                                                 input logic [VALUE_W-1:0] req_val);
        set_reply_t r;
        int         hit;
        hit = -1;
        for (int i = 0; i < held_count; i++)
            if (hit < 0 && same_number(held_values[i], req_val))
                hit = i;
        r.found    = (hit >= 0);
        r.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
        r.status   = ST_DONE;
        case (req_op)
            OP_INSERT:
            begin
                if (hit >= 0)
                    r.status = ST_HOLD;
                else if (held_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    held_values[held_count] = req_val;
                    held_count++;
                end
            end
            OP_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_HOLD;
                else
                begin
                    for (int i = hit; i + 1 < held_count; i++)
                        held_values[i] = held_values[i + 1];
                    held_count--;
                end
            end
            default:
                r.status = ST_DONE;
        endcase
        r.occupancy = held_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] special_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(4))
            0: v[62:0] = '0;
            1: v[62:0] = {11'h7FF, 52'h0};
            2:
            begin
                v[62:52] = 11'h7FF;
                if (v[51:0] == '0)
                    v[0] = 1'b1;
            end
            3: v[62:52] = '0;
            default: v[62:52] = 11'h7FE;
        endcase
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] choose_value(input logic [OP_W-1:0] req_op);
        logic [VALUE_W-1:0] v;
        int                 sel;
        sel = $urandom_range(99);
        if (held_count != 0 && sel < ((req_op == OP_REMOVE) ? 60 : 35))
            v = held_values[$urandom_range(held_count - 1)];
        else if (sel < 70)
            v = pool[$urandom_range(POOL_N - 1)];
        else if (sel < 82)
            v = special_value();
        else
        begin
            v = {$urandom, $urandom};
            pool[$urandom_range(POOL_N - 1)] = v;
        end
        // keep NaN out of the table; it could never be removed again
        if (req_op == OP_INSERT && held_count < TABLE_DEPTH && nan_pattern(v))
            v[62:52] = 11'h3FF;
        return v;
    endfunction

    task automatic issue(input logic [OP_W-1:0]    req_op,
                         input logic [VALUE_W-1:0] req_val,
                         input logic               use_typed,
                         input set_reply_t         typed_reply);
        set_reply_t predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        value    <= req_val;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_reply(req_op, req_val);
        pending_replies.push_back(use_typed ? typed_reply : predicted);
        requests_sent++;
    endtask

    task automatic take_reply();
        set_reply_t want;
        replies_seen++;
        if (found)
            hit_count++;
        if (status == ST_FULL)
            refused_count++;
        if (pending_replies.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected reply %0d: found=%0d position=%0d status=%0d occupancy=%0d",
                         replies_seen, found, position, status, occupancy);
        end
        else
        begin
            want = pending_replies.pop_front();
            if (found !== want.found || position !== want.position ||
                status !== want.status || occupancy !== want.occupancy)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("reply %0d expected found=%0d pos=%0d status=%0d occupancy=%0d",
                             replies_seen, want.found, want.position, want.status,
                             want.occupancy);
                    $display("reply %0d got      found=%0d pos=%0d status=%0d occupancy=%0d",
                             replies_seen, found, position, status, occupancy);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                take_reply();
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, pending_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [OP_W-1:0]    rq_op;
        logic [VALUE_W-1:0] rq_val;
        int                 sel;
        logic               filling;
        for (int i = 0; i < POOL_N; i++)
            pool[i] = (i < 6) ? special_value() : {$urandom, $urandom};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 35;
        stall_pct     = 62;
        foreach (DIRECTED[i])
            issue(DIRECTED[i].r_op, DIRECTED[i].r_val, DIRECTED[i].typed, DIRECTED[i].want);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 62 : 0;
            stall_pct     = (ph == 0) ? 62 : (ph == 1) ? 35 : 0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                // alternate filling and draining stretches
                filling = ((k / 60) % 2) == 0;
                sel = $urandom_range(99);
                if (sel < 5)
                    rq_op = OP_SPARE;
                else if (sel < 25)
                    rq_op = OP_LOOKUP;
                else
                    rq_op = (sel < (filling ? 80 : 45)) ? OP_INSERT : OP_REMOVE;
                rq_val = choose_value(rq_op);
                issue(rq_op, rq_val, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d requests and %0d replies over three idle mixes", requests_sent,
                 replies_seen);
        $display("hits %0d, inserts refused on a full table %0d, mismatches %0d",
                 hit_count, refused_count, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
sv/dvst_pkg.sv
sv/dvst_ctrl.sv
sv/dvst_dpath.sv
sv/dedup_value_set_table.sv
bench/tb.sv
